/* rtl/core/besa_pkg.sv */
// ============================================================================
// besa_pkg
// Shared types and constants of the bilinear event splat accumulator.
// ============================================================================
package besa_pkg;

    localparam int POS_BITS   = 20;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int Q16_BITS   = 16;
    localparam int WGT_W      = Q16_BITS + 1;
    localparam int ONE_Q16    = 65536;
    localparam int PIX_OUT_W  = 32;
    localparam int RD_COORD_W = 9;

    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = CFG_W'(500);
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = CFG_W'(500);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] OP_SPLAT      = 2'd0;
    localparam logic [1:0] OP_READ       = 2'd1;
    localparam logic [1:0] OP_READ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic                       polarity;
        logic [RD_COORD_W-1:0]      read_col;
        logic [RD_COORD_W-1:0]      read_row;
    } cmd_t;

    typedef struct packed {
        logic signed [PIX_OUT_W-1:0] pixel_value;
        logic                        saturated_seen;
    } result_t;

endpackage

/* rtl/core/besa_nbr_calc.sv */
// ============================================================================
// besa_nbr_calc
// Address, range check and bilinear weight of one of the four neighbours
// of an event position.
// ============================================================================
module besa_nbr_calc
    import besa_pkg::*;
#(
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 512,
    parameter int FRAC_BITS = 8,
    parameter int ADDR_W    = 18
)
(
    input  logic signed [POS_BITS-1:0] pos_x,
    input  logic signed [POS_BITS-1:0] pos_y,
    input  logic [1:0]                 sel,
    input  logic [CFG_W-1:0]           image_width,
    input  logic [CFG_W-1:0]           image_height,
    output logic                       nbr_valid,
    output logic [ADDR_W-1:0]          nbr_addr,
    output logic [WGT_W-1:0]           nbr_weight
);

    localparam int INT_W = POS_BITS - FRAC_BITS;
    localparam int CMP_W = POS_BITS + 2;
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int SHIFT = Q16_BITS - FRAC_BITS;
    localparam int PROD_W = 2 * WGT_W;

    localparam logic signed [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLS);
    localparam logic signed [CMP_W-1:0] MAX_R = CMP_W'(MAX_ROWS);

    logic signed [INT_W-1:0] x0;
    logic signed [INT_W-1:0] y0;
    logic signed [CMP_W-1:0] col;
    logic signed [CMP_W-1:0] row;
    logic signed [CMP_W-1:0] w_ext;
    logic signed [CMP_W-1:0] h_ext;
    logic signed [CMP_W-1:0] lim_c;
    logic signed [CMP_W-1:0] lim_r;
    logic [WGT_W-1:0]        fx;
    logic [WGT_W-1:0]        fy;
    logic [WGT_W-1:0]        fac_x;
    logic [WGT_W-1:0]        fac_y;
    logic [PROD_W-1:0]       prod;

    // floor is the integer part of the two's complement value
    assign x0 = pos_x[POS_BITS-1:FRAC_BITS];
    assign y0 = pos_y[POS_BITS-1:FRAC_BITS];

    // sel[1] steps one column right, sel[0] one row down
    assign col = CMP_W'(x0) + CMP_W'(sel[1]);
    assign row = CMP_W'(y0) + CMP_W'(sel[0]);

    assign w_ext = CMP_W'(image_width);
    assign h_ext = CMP_W'(image_height);
    assign lim_c = (w_ext < MAX_C) ? w_ext : MAX_C;
    assign lim_r = (h_ext < MAX_R) ? h_ext : MAX_R;

    assign nbr_valid = !col[CMP_W-1] && !row[CMP_W-1] && (col < lim_c) && (row < lim_r);

    assign nbr_addr = ADDR_W'(ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                              + ADDR_W'(col[COL_W-1:0]));

    // fractions scaled to q0.16
    assign fx = WGT_W'(pos_x[FRAC_BITS-1:0]) << SHIFT;
    assign fy = WGT_W'(pos_y[FRAC_BITS-1:0]) << SHIFT;

    assign fac_x = sel[1] ? fx : WGT_W'(WGT_W'(ONE_Q16) - fx);
    assign fac_y = sel[0] ? fy : WGT_W'(WGT_W'(ONE_Q16) - fy);

    assign prod       = PROD_W'(fac_x) * PROD_W'(fac_y);
    assign nbr_weight = prod[Q16_BITS+WGT_W-1:Q16_BITS];

endmodule

/* rtl/core/bilinear_event_splat_accumulator.sv */
// ============================================================================
// bilinear_event_splat_accumulator
// Bilinear splat of events into a pixel sum memory, with read and
// read-and-clear of single pixels.
// ============================================================================
// splat: busy from the accept until the fourth write (read then write per neighbour,
//   four neighbours in turn through the memory); the next item is taken once idle
// read / read-clear: RD_READ, then RD_DATA, then a registered result strobe; next item once idle
// op 3 and the receiver side take no time: busy stays low, results are never held
// after reset all MAX_COLS*MAX_ROWS words (262144 at the default size) are zeroed
//   with busy high; config writes are taken during that pass
// ============================================================================
module bilinear_event_splat_accumulator
    import besa_pkg::*;
#(
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 512,
    parameter int FRAC_BITS = 8,
    parameter int SUM_BITS  = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 result_valid,
    output result_t              result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EXT_W  = ((SUM_BITS > WGT_W + 1) ? SUM_BITS : WGT_W + 1) + 1;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic signed [EXT_W-1:0] SMAX =
        {{(EXT_W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SMIN = ~SMAX;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NB_READ,
        ST_NB_WRITE,
        ST_RD_READ,
        ST_RD_DATA
    } state_t;

    state_t                      state_reg;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic [1:0]                  nb_sel_reg;
    logic                        sat_reg;
    logic                        result_valid_reg;
    result_t                     result_reg;
    logic [CFG_W-1:0]            width_reg;
    logic [CFG_W-1:0]            height_reg;

    cmd_t                        cmd_reg;
    logic                        nb_valid_reg;
    logic [ADDR_W-1:0]           nb_addr_reg;
    logic [WGT_W-1:0]            nb_weight_reg;

    logic signed [SUM_BITS-1:0]  pix_mem [DEPTH];
    logic signed [SUM_BITS-1:0]  mem_rdata_reg;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic signed [SUM_BITS-1:0]  mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;

    logic                        nbr_valid;
    logic [ADDR_W-1:0]           nbr_addr;
    logic [WGT_W-1:0]            nbr_weight;

    logic                        rd_in_store;
    logic [ADDR_W-1:0]           rd_addr;

    logic signed [EXT_W-1:0]     w_ext;
    logic signed [EXT_W-1:0]     delta;
    logic signed [EXT_W-1:0]     sum_ext;
    logic                        ovf_hi;
    logic                        ovf_lo;
    logic signed [SUM_BITS-1:0]  pix_next;

    besa_nbr_calc #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS),
        .ADDR_W    (ADDR_W)
    ) u_nbr (
        .pos_x        (cmd_reg.pos_x),
        .pos_y        (cmd_reg.pos_y),
        .sel          (nb_sel_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .nbr_valid    (nbr_valid),
        .nbr_addr     (nbr_addr),
        .nbr_weight   (nbr_weight)
    );

    // read address of a pixel read item
    assign rd_in_store = (int'(cmd_reg.read_col) < MAX_COLS)
                      && (int'(cmd_reg.read_row) < MAX_ROWS);
    assign rd_addr = ADDR_W'(ADDR_W'(cmd_reg.read_row) * ADDR_W'(MAX_COLS)
                             + ADDR_W'(cmd_reg.read_col));

    // accumulate with saturation
    assign w_ext   = EXT_W'(nb_weight_reg);
    assign delta   = cmd_reg.polarity ? w_ext : -w_ext;
    assign sum_ext = EXT_W'(mem_rdata_reg) + delta;
    assign ovf_hi  = sum_ext > SMAX;
    assign ovf_lo  = sum_ext < SMIN;

    always_comb
    begin
        if (ovf_hi)
        begin
            pix_next = SMAX[SUM_BITS-1:0];
        end
        else if (ovf_lo)
        begin
            pix_next = SMIN[SUM_BITS-1:0];
        end
        else
        begin
            pix_next = sum_ext[SUM_BITS-1:0];
        end
    end

    // memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = nb_addr_reg;
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
            end
            ST_NB_WRITE:
            begin
                mem_we    = nb_valid_reg;
                mem_wdata = pix_next;
            end
            ST_RD_DATA:
            begin
                mem_we    = (cmd_reg.op == OP_READ_CLEAR) && rd_in_store;
                mem_waddr = rd_addr;
            end
            default:
            begin
            end
        endcase
    end

    assign mem_re    = (state_reg == ST_NB_READ) || (state_reg == ST_RD_READ);
    assign mem_raddr = (state_reg == ST_NB_READ) ? nbr_addr : rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pix_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= pix_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_RESET;
            height_reg <= CFG_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // item payload and per-neighbour values
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_NB_READ)
        begin
            nb_valid_reg  <= nbr_valid;
            nb_addr_reg   <= nbr_addr;
            nb_weight_reg <= nbr_weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            nb_sel_reg       <= '0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= ADDR_W'(clr_addr_reg + 1'b1);
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        nb_sel_reg <= '0;
                        case (cmd.op)
                            OP_SPLAT:                state_reg <= ST_NB_READ;
                            OP_READ, OP_READ_CLEAR:  state_reg <= ST_RD_READ;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_NB_READ:
                begin
                    state_reg <= ST_NB_WRITE;
                end
                ST_NB_WRITE:
                begin
                    if (nb_valid_reg && (ovf_hi || ovf_lo))
                    begin
                        sat_reg <= 1'b1;
                    end
                    nb_sel_reg <= 2'(nb_sel_reg + 1'b1);
                    if (nb_sel_reg == 2'd3)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_NB_READ;
                    end
                end
                ST_RD_READ:
                begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA:
                begin
                    result_valid_reg           <= 1'b1;
                    result_reg.pixel_value     <= rd_in_store ? PIX_OUT_W'(mem_rdata_reg) : '0;
                    result_reg.saturated_seen  <= sat_reg;
                    state_reg                  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a result only follows the cycle that holds the read data
    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_RD_DATA))
        else $error("result strobe without a pixel read");

    // no write while a read of the same item is being issued
    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_NB_READ && state_reg != ST_RD_READ))
        else $error("memory write during a read issue cycle");

    // saturation flag is sticky
    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |=> sat_reg)
        else $error("saturation flag dropped");

    // the fourth neighbour ends the splat
    a_splat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NB_WRITE && nb_sel_reg == 2'd3) |=> (state_reg == ST_IDLE))
        else $error("splat did not end after four neighbours");

endmodule
